>>> rtl/core/wfpd_pkg.sv
`default_nettype none
package wfpd_pkg;
	localparam int NumRegs = 6;
	localparam int AtanW = 17;
	localparam int CordW = 36;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_VEC_INIT,
		ST_VEC,
		ST_ROT_INIT,
		ST_ROT,
		ST_MUL_B,
		ST_MUL_L,
		ST_ERR,
		ST_MUL_P,
		ST_MUL_D,
		ST_STEER,
		ST_OUT
	} state_t;

	typedef enum logic [2:0] {
		REG_PROP   = 3'd0,
		REG_DERIV  = 3'd1,
		REG_TARGET = 3'd2,
		REG_LOOK   = 3'd3,
		REG_BEAM_A = 3'd4,
		REG_BEAM_B = 3'd5
	} reg_idx_t;

	function automatic logic [AtanW-1:0] atan_lut(input logic [4:0] i);
		logic [AtanW-1:0] r;
		case (i)
			5'd0:  r = 17'd51472;
			5'd1:  r = 17'd30386;
			5'd2:  r = 17'd16055;
			5'd3:  r = 17'd8150;
			5'd4:  r = 17'd4091;
			5'd5:  r = 17'd2047;
			5'd6:  r = 17'd1024;
			5'd7:  r = 17'd512;
			5'd8:  r = 17'd256;
			5'd9:  r = 17'd128;
			5'd10: r = 17'd64;
			5'd11: r = 17'd32;
			5'd12: r = 17'd16;
			5'd13: r = 17'd8;
			5'd14: r = 17'd4;
			5'd15: r = 17'd2;
			5'd16: r = 17'd1;
			default: r = '0;
		endcase
		return r;
	endfunction

	function automatic logic signed [15:0] sat16(input logic signed [47:0] v);
		logic signed [15:0] r;
		if (v > 48'sd32767) r = 16'sh7fff;
		else if (v < -48'sd32768) r = -16'sh8000;
		else r = v[15:0];
		return r;
	endfunction
endpackage
`default_nettype wire

>>> rtl/core/wfpd_cordic.sv
`default_nettype none
module wfpd_cordic
	import wfpd_pkg::*;
#(
	parameter int Steps = 16
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     load,
	input  wire logic                     vec_mode,
	input  wire logic signed [CordW-1:0]  x_in,
	input  wire logic signed [CordW-1:0]  y_in,
	input  wire logic signed [23:0]       z_in,
	output logic                          done,
	output logic signed [CordW-1:0]       x_out,
	output logic signed [CordW-1:0]       y_out,
	output logic signed [23:0]            z_out
);
	logic signed [CordW-1:0] x_q, y_q;
	logic signed [23:0] z_q;
	logic [4:0] i_q;
	logic busy_q, mode_q, done_q;
	logic signed [CordW-1:0] xs, ys;
	logic neg;
	logic signed [23:0] at;

	assign xs = x_q >>> i_q;
	assign ys = y_q >>> i_q;
	assign at = 24'(signed'({1'b0, atan_lut(i_q)}));
	// vectoring drives y to zero, rotation drives z to zero
	assign neg = mode_q ? (y_q < 0) : (z_q < 0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			i_q <= '0;
			mode_q <= 1'b0;
			done_q <= 1'b0;
		end else if (load) begin
			busy_q <= 1'b1;
			i_q <= '0;
			mode_q <= vec_mode;
			done_q <= 1'b0;
		end else if (busy_q) begin
			// done rises once the final iteration has landed in x, y, z
			done_q <= (i_q == 5'(Steps - 1));
			if (i_q == 5'(Steps - 1)) busy_q <= 1'b0;
			i_q <= i_q + 5'd1;
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			x_q <= x_in;
			y_q <= y_in;
			z_q <= z_in;
		end else if (busy_q) begin
			if (neg ^ ~mode_q) begin
				x_q <= x_q - ys;
				y_q <= y_q + xs;
				z_q <= mode_q ? z_q - at : z_q - at;
			end else begin
				x_q <= x_q + ys;
				y_q <= y_q - xs;
				z_q <= z_q + at;
			end
		end
	end

	assign done = done_q;
	assign x_out = x_q;
	assign y_out = y_q;
	assign z_out = z_q;
endmodule
`default_nettype wire

>>> rtl/core/wall_follow_pd_steering.sv
// channel | direction | handshake          | payload
// in      | input     | in_valid/in_ready  | range_sample, last_sample
// out     | output    | out_valid/out_ready| steer_cmd, wall_error, scan_valid
// cfg     | input     | cfg_we             | cfg_index, cfg_data
// non-final samples are accepted back to back while idle; a scan end with both beams
// seen is worked by the shared cordic, iterating one step per cycle, and one shared
// multiplier used for each product in turn
// input is not ready while a scan end is being worked or its result waits
// reset is asynchronous active low and clears counters, flags, config and state; datapath registers are not reset
`default_nettype none
module wall_follow_pd_steering
	import wfpd_pkg::*;
#(
	parameter int MAX_BEAMS = 2048,
	parameter int CORDIC_STEPS = 16
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic [15:0]        range_sample,
	input  wire logic               last_sample,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic signed [15:0]      steer_cmd,
	output logic signed [15:0]      wall_error,
	output logic                    scan_valid,
	input  wire logic               cfg_we,
	input  wire logic [2:0]         cfg_index,
	input  wire logic [15:0]        cfg_data
);
	logic signed [15:0] kp_q, kd_q;
	logic [15:0] tgt_q, look_q, a_q, b_q;
	logic [10:0] ia_q, ib_q;
	logic [11:0] count_q;
	logic [1:0] seen_q;
	logic signed [15:0] prev_q;
	state_t state_q, state_d;

	logic signed [CordW-1:0] cx_in, cy_in, cx, cy;
	logic signed [23:0] cz_in, cz;
	logic c_load, c_vec, c_done;
	logic signed [23:0] alpha_q;
	logic signed [CordW-1:0] cos_q, sin_q;
	// shared multiplier operands
	logic signed [CordW-1:0] m_a;
	logic signed [17:0] m_b;
	logic signed [53:0] prod;
	logic signed [47:0] acc_q;
	logic signed [15:0] e_q;
	logic signed [15:0] steer_q;
	logic valid_q;

	wire accept = in_valid && in_ready;

	// cfg writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kp_q <= 16'sd2048; kd_q <= 16'sd41; tgt_q <= 16'd870; look_q <= 16'd410;
			ia_q <= 11'd779; ib_q <= 11'd899;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_PROP:   kp_q <= cfg_data;
				REG_DERIV:  kd_q <= cfg_data;
				REG_TARGET: tgt_q <= cfg_data;
				REG_LOOK:   look_q <= cfg_data;
				REG_BEAM_A: ia_q <= cfg_data[10:0];
				REG_BEAM_B: ib_q <= cfg_data[10:0];
				default: ;
			endcase
		end
	end

	// beam capture
	wire in_range = 32'(count_q) < MAX_BEAMS;
	wire hit_a = in_range && (count_q == {1'b0, ia_q});
	wire hit_b = in_range && (count_q == {1'b0, ib_q});
	wire [15:0] a_now = hit_a ? range_sample : a_q;
	wire [15:0] b_now = hit_b ? range_sample : b_q;
	wire [1:0] seen_now = seen_q | {hit_b, hit_a};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0; seen_q <= '0; a_q <= '0; b_q <= '0;
		end else if (accept) begin
			a_q <= a_now;
			b_q <= b_now;
			seen_q <= seen_now;
			if (last_sample) count_q <= '0;
			else if (count_q != 12'hfff) count_q <= count_q + 12'd1;
		end else if (state_q == ST_OUT && out_ready) begin
			seen_q <= '0; a_q <= '0; b_q <= '0;
		end
	end

	// vector: y = round(a*sqrt3 in Q.16) - 2b, scaled by 2^8
	logic [33:0] a_sqrt3;
	assign a_sqrt3 = 34'(a_q) * 34'd113512 + 34'd32768;
	logic signed [19:0] vy;
	assign vy = 20'(signed'({2'b0, a_sqrt3[33:16]})) - 20'(signed'({3'b0, b_q, 1'b0}));

	always_comb begin
		cx_in = '0; cy_in = '0; cz_in = '0; c_vec = 1'b0; c_load = 1'b0;
		if (state_q == ST_VEC_INIT) begin
			c_load = 1'b1; c_vec = 1'b1;
			cx_in = CordW'(signed'({1'b0, a_q})) <<< 8;
			cy_in = CordW'(vy) <<< 8;
		end else if (state_q == ST_ROT_INIT) begin
			c_load = 1'b1;
			cx_in = CordW'(39797);
			cz_in = alpha_q;
		end
	end

	wfpd_cordic #(.Steps(CORDIC_STEPS)) u_cordic (
		.clk(clk), .arst_n(arst_n), .load(c_load), .vec_mode(c_vec),
		.x_in(cx_in), .y_in(cy_in), .z_in(cz_in), .done(c_done),
		.x_out(cx), .y_out(cy), .z_out(cz)
	);

	always_comb begin
		m_a = '0; m_b = '0;
		case (state_q)
			ST_MUL_B: begin m_a = cos_q; m_b = 18'(signed'({2'b0, b_q})); end
			ST_MUL_L: begin m_a = sin_q; m_b = 18'(signed'({2'b0, look_q})); end
			ST_MUL_P: begin m_a = CordW'(e_q); m_b = 18'(kp_q); end
			ST_MUL_D: begin
				m_a = CordW'(e_q) - CordW'(prev_q);
				m_b = 18'(kd_q);
			end
			default: ;
		endcase
	end
	// cos/sin magnitudes stay under 2^17, so the low bits of m_a suffice
	assign prod = 54'(signed'(m_a[19:0])) * 54'(m_b);

	logic signed [47:0] d_val;
	assign d_val = (acc_q + 48'sd32768) >>> 16;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE; prev_q <= '0; valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_STEER && valid_q) prev_q <= e_q;
			if (state_q == ST_IDLE && accept && last_sample) valid_q <= (seen_now == 2'b11);
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_VEC: if (c_done) alpha_q <= (a_q == 0 && b_q == 0) ? 24'sd0 : cz;
			ST_ROT: if (c_done) begin cos_q <= cx; sin_q <= cy; end
			ST_MUL_B: acc_q <= 48'(prod);
			ST_MUL_L: acc_q <= acc_q + 48'(prod);
			ST_ERR: e_q <= sat16(d_val - 48'(tgt_q));
			ST_MUL_P: acc_q <= 48'(prod);
			ST_MUL_D: acc_q <= acc_q + 48'(prod);
			ST_STEER: steer_q <= sat16((acc_q + 48'sd512) >>> 10);
			default: ;
		endcase
	end

	always_comb begin
		state_d = state_q;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid && last_sample) state_d = (seen_now == 2'b11) ? ST_VEC_INIT : ST_OUT;
			end
			ST_VEC_INIT: state_d = ST_VEC;
			ST_VEC:      if (c_done) state_d = ST_ROT_INIT;
			ST_ROT_INIT: state_d = ST_ROT;
			ST_ROT:      if (c_done) state_d = ST_MUL_B;
			ST_MUL_B:    state_d = ST_MUL_L;
			ST_MUL_L:    state_d = ST_ERR;
			ST_ERR:      state_d = ST_MUL_P;
			ST_MUL_P:    state_d = ST_MUL_D;
			ST_MUL_D:    state_d = ST_STEER;
			ST_STEER:    state_d = ST_OUT;
			ST_OUT:      if (out_ready) state_d = ST_IDLE;
			default:     state_d = ST_IDLE;
		endcase
	end

	assign out_valid = (state_q == ST_OUT);
	assign steer_cmd = valid_q ? steer_q : 16'sd0;
	assign wall_error = valid_q ? e_q : 16'sd0;
	assign scan_valid = valid_q;
endmodule
`default_nettype wire

>>> rtl/core/wfpd_checker.sv
`default_nettype none
module wfpd_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	input wire logic in_ready,
	input wire logic last_sample,
	input wire logic out_valid,
	input wire logic out_ready,
	input wire logic [15:0] steer_cmd,
	input wire logic [15:0] wall_error,
	input wire logic scan_valid
);
	a_no_in_while_out: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !in_ready) else $error("input ready during result");
	a_last_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && last_sample) |=> !in_ready) else $error("ready after scan end");
	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !scan_valid) |-> (steer_cmd == 16'd0 && wall_error == 16'd0))
		else $error("invalid result nonzero");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(wall_error)))
		else $error("result dropped");
endmodule

bind wall_follow_pd_steering wfpd_checker u_chk (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
	.last_sample(last_sample), .out_valid(out_valid), .out_ready(out_ready),
	.steer_cmd(steer_cmd), .wall_error(wall_error), .scan_valid(scan_valid)
);
`default_nettype wire

>>> bench/wall_follow_pd_steering_tb.sv
`timescale 1ns / 100ps
`default_nettype none
module wall_follow_pd_steering_tb;
	import wfpd_pkg::*;

	// one lidar beam as driven on the input channel
	typedef struct packed {
		logic [15:0] range_val;
		logic        last;
	} beam_t;

	// one steering command as seen on the output channel
	typedef struct packed {
		logic signed [15:0] steer;
		logic signed [15:0] err;
		logic               valid;
	} steer_t;

	localparam int WATCHDOG_LIMIT = 5000;
	localparam int SETTLE_CYCLES = 80;
	localparam int ROT_STEPS = 16;
	localparam int CAPACITY = 2048;
	localparam longint ATAN_Q16 [ROT_STEPS] = '{51472, 30386, 16055, 8150, 4091, 2047,
		1024, 512, 256, 128, 64, 32, 16, 8, 4, 2};

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [15:0] range_sample = '0;
	logic last_sample = 1'b0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic signed [15:0] steer_cmd;
	logic signed [15:0] wall_error;
	logic scan_valid;
	logic cfg_we = 1'b0;
	logic [2:0] cfg_index = '0;
	logic [15:0] cfg_data = '0;

	wall_follow_pd_steering i_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.range_sample(range_sample), .last_sample(last_sample),
		.out_valid(out_valid), .out_ready(out_ready),
		.steer_cmd(steer_cmd), .wall_error(wall_error), .scan_valid(scan_valid),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always #10 clk = ~clk;

	// predictor copy of the block's registers
	logic signed [15:0] kp, kd;
	logic [15:0] target_m, look_m;
	logic [10:0] beam_a_idx, beam_b_idx;
	// predictor copy of the scan state
	int unsigned beam_cnt;
	logic [15:0] range_a, range_b;
	logic [1:0] seen;
	longint last_err;

	beam_t pending_beams[$];
	steer_t expected_cmds[$];
	int errors = 0;
	int sender_idle_pct = 0;
	int recv_stall_pct = 0;
	int quiet_cycles = 0;

	function automatic logic signed [15:0] clamp16(input longint v);
		if (v > 32767) return 16'sh7fff;
		if (v < -32768) return -16'sh8000;
		return v[15:0];
	endfunction

	// wall geometry and pd law for one finished scan
	function automatic steer_t steer_from_beams(input longint a, input longint b);
		longint x, y, z, c, s, xs, ys, d, e, pd;
		steer_t r;
		// vectoring: angle of (a*sin30, a*cos30 - b), both scaled by 2 then 2^8
		x = a * 256;
		y = (((a * 113512 + 32768) >>> 16) - 2 * b) * 256;
		z = 0;
		if (x != 0 || y != 0) begin
			for (int i = 0; i < ROT_STEPS; i++) begin
				xs = x >>> i;
				ys = y >>> i;
				if (y < 0) begin
					x = x - ys; y = y + xs; z = z - ATAN_Q16[i];
				end else begin
					x = x + ys; y = y - xs; z = z + ATAN_Q16[i];
				end
			end
		end
		// rotation: cos and sin of alpha, gain pre-compensated
		c = 39797;
		s = 0;
		for (int i = 0; i < ROT_STEPS; i++) begin
			xs = c >>> i;
			ys = s >>> i;
			if (z >= 0) begin
				c = c - ys; s = s + xs; z = z - ATAN_Q16[i];
			end else begin
				c = c + ys; s = s - xs; z = z + ATAN_Q16[i];
			end
		end
		d = (b * c + longint'(look_m) * s + 32768) >>> 16;
		e = clamp16(d - longint'(target_m));
		pd = longint'(kp) * e + longint'(kd) * (e - last_err);
		r.steer = clamp16((pd + 512) >>> 10);
		r.err = e[15:0];
		r.valid = 1'b1;
		last_err = e;
		return r;
	endfunction

	// advance the scan state by one accepted beam, queue a command at scan end
	function automatic void absorb_beam(input beam_t bm);
		steer_t r;
		if (beam_cnt < CAPACITY) begin
			if (beam_cnt == beam_a_idx) begin
				range_a = bm.range_val; seen[0] = 1'b1;
			end
			if (beam_cnt == beam_b_idx) begin
				range_b = bm.range_val; seen[1] = 1'b1;
			end
		end
		if (!bm.last) begin
			if (beam_cnt < 4095) beam_cnt++;
			return;
		end
		// a scan missing a beam reports invalid and keeps the stored error
		if (seen == 2'b11) r = steer_from_beams(longint'(range_a), longint'(range_b));
		else r = '0;
		expected_cmds.push_back(r);
		beam_cnt = 0;
		range_a = '0;
		range_b = '0;
		seen = '0;
	endfunction

	// driver: one input transaction per accepted beam
	always @(posedge clk) begin
		logic taken;
		taken = in_valid && in_ready;
		if (taken) absorb_beam('{range_val: range_sample, last: last_sample});
		if (!in_valid || taken) begin
			if (pending_beams.size() > 0 && arst_n &&
					$urandom_range(99, 0) >= sender_idle_pct) begin
				beam_t bm;
				bm = pending_beams.pop_front();
				in_valid <= 1'b1;
				range_sample <= bm.range_val;
				last_sample <= bm.last;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// monitor: compare each output transaction with the oldest expectation
	always @(posedge clk) begin
		if (out_valid && out_ready) begin
			if (expected_cmds.size() == 0) begin
				$error("unexpected steering transaction: steer %0d err %0d valid %0b",
					steer_cmd, wall_error, scan_valid);
				errors++;
			end else begin
				steer_t ex;
				ex = expected_cmds.pop_front();
				if (steer_cmd !== ex.steer) begin
					$error("steer_cmd expected %0d actual %0d", ex.steer, steer_cmd);
					errors++;
				end
				if (wall_error !== ex.err) begin
					$error("wall_error expected %0d actual %0d", ex.err, wall_error);
					errors++;
				end
				if (scan_valid !== ex.valid) begin
					$error("scan_valid expected %0b actual %0b", ex.valid, scan_valid);
					errors++;
				end
			end
		end
		out_ready <= ($urandom_range(99, 0) >= recv_stall_pct);
	end

	// watchdog on cycles where nothing moves
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we) quiet_cycles <= 0;
		else quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		case (idx)
			REG_PROP:   kp = val;
			REG_DERIV:  kd = val;
			REG_TARGET: target_m = val;
			REG_LOOK:   look_m = val;
			REG_BEAM_A: beam_a_idx = val[10:0];
			REG_BEAM_B: beam_b_idx = val[10:0];
			default: ;
		endcase
	endtask

	task automatic write_done();
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// wait until every beam is sent and every command is back, then let the pipe drain
	task automatic wait_idle();
		while (pending_beams.size() > 0 || in_valid || expected_cmds.size() > 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	function automatic logic [15:0] pick_extreme();
		case ($urandom_range(3, 0))
			0: return 16'h8000;
			1: return 16'h7fff;
			2: return $urandom_range(1, 0) ? 16'hffff : 16'h0000;
			default: return 16'($urandom());
		endcase
	endfunction

	function automatic logic [15:0] pick_range();
		case ($urandom_range(5, 0))
			0: return 16'h0000;
			1: return 16'hffff;
			2, 3: return 16'($urandom());
			default: return 16'($urandom_range(4000, 200));
		endcase
	endfunction

	task automatic queue_scan(input int n, input logic [15:0] fixed0, input logic [15:0] fixed1,
			input bit use_fixed);
		beam_t bm;
		for (int k = 0; k < n; k++) begin
			bm.range_val = pick_range();
			if (use_fixed && k == 0) bm.range_val = fixed0;
			if (use_fixed && k == 1) bm.range_val = fixed1;
			bm.last = (k == n - 1);
			pending_beams.push_back(bm);
		end
	endtask

	initial begin
		int count;
		int n;
		kp = 16'sd2048; kd = 16'sd41; target_m = 16'd870; look_m = 16'd410;
		beam_a_idx = 11'd779; beam_b_idx = 11'd899;
		beam_cnt = 0; range_a = '0; range_b = '0; seen = '0; last_err = 0;

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// directed: a on beam 0, b on beam 1, field extremes and the zero vector
		write_reg(REG_BEAM_A, 16'd0);
		write_reg(REG_BEAM_B, 16'd1);
		write_done();
		queue_scan(2, 16'h0000, 16'h0000, 1'b1);
		queue_scan(2, 16'hffff, 16'hffff, 1'b1);
		queue_scan(2, 16'h0000, 16'hffff, 1'b1);
		queue_scan(2, 16'hffff, 16'h0000, 1'b1);
		queue_scan(3, 16'd870, 16'd1000, 1'b1);
		// scan ends before beam b arrives
		queue_scan(1, 16'd500, 16'd0, 1'b1);
		queue_scan(3, 16'd1200, 16'd900, 1'b1);
		wait_idle();

		// equal indices: one sample fills both, captured on the last sample itself
		write_reg(REG_BEAM_B, 16'd0);
		write_done();
		queue_scan(1, 16'd700, 16'd0, 1'b1);
		queue_scan(1, 16'hffff, 16'd0, 1'b1);
		wait_idle();

		// highest indices with upper data bits dropped, never reached by a short scan
		write_reg(REG_BEAM_A, 16'hf7ff);
		write_reg(REG_BEAM_B, 16'd2046);
		write_done();
		queue_scan(40, 16'd0, 16'd0, 1'b0);
		wait_idle();

		// random phases cycling through the idling patterns
		for (int ph = 0; ph < 8; ph++) begin
			case (ph % 4)
				0: begin sender_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin sender_idle_pct = 62; recv_stall_pct = 0;  end
				2: begin sender_idle_pct = 0;  recv_stall_pct = 62; end
				default: begin sender_idle_pct = 34; recv_stall_pct = 34; end
			endcase
			write_reg(REG_PROP, pick_extreme());
			write_reg(REG_DERIV, pick_extreme());
			write_reg(REG_TARGET, pick_extreme());
			write_reg(REG_LOOK, pick_extreme());
			// upper data bits are random to check they are dropped
			write_reg(REG_BEAM_A, {5'($urandom()), 11'($urandom_range(12, 0))});
			write_reg(REG_BEAM_B, {5'($urandom()), 11'($urandom_range(16, 0))});
			// indices past the register list are ignored
			write_reg(3'(NumRegs), 16'($urandom()));
			write_reg(3'(NumRegs + 1), 16'($urandom()));
			write_done();
			count = 0;
			while (count < 130) begin
				// mostly scans long enough for both beams, some cut short
				if ($urandom_range(9, 0) < 8) n = $urandom_range(24, 17);
				else n = $urandom_range(12, 1);
				queue_scan(n, 16'd0, 16'd0, 1'b0);
				count += n;
			end
			wait_idle();
		end

		if (errors == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end
endmodule
`default_nettype wire

>>> wall_follow_pd_steering.f
rtl/core/wfpd_pkg.sv
rtl/core/wfpd_cordic.sv
rtl/core/wall_follow_pd_steering.sv
rtl/core/wfpd_checker.sv
bench/wall_follow_pd_steering_tb.sv
